// ===== src/blpc_pkg.sv =====
// ----------------------------------------------------------------------------
// blpc_pkg
// Shared types and constants for the breathing LED PWM controller.
// ----------------------------------------------------------------------------
package blpc_pkg;

    // Event kind carried on the input tuser
    localparam int OP_W = 2;
    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_ADC    = 2'd1,
        OP_BUTTON = 2'd2
    } op_t;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TOP_COUNT = 2'd0,
        CFG_MIN_STEP  = 2'd1,
        CFG_STEP_GAIN = 2'd2
    } cfg_idx_t;

    // Field widths fixed by the register map
    localparam int CMP_W      = 8;
    localparam int STEP_CFG_W = 16;
    localparam int OUT_DATA_W = 16;

    // Reset values
    localparam logic [CMP_W-1:0]      RST_TOP_COUNT = 8'd167;
    localparam logic [STEP_CFG_W-1:0] RST_MIN_STEP  = 16'd393;
    localparam logic [STEP_CFG_W-1:0] RST_STEP_GAIN = 16'd21627;
    localparam logic [STEP_CFG_W-1:0] RST_STEP      = 16'd393;
    localparam logic [31:0]           RST_DUTY      = 32'd32768;
    localparam logic [CMP_W-1:0]      RST_COMPARE   = 8'd83;

endpackage

// ===== src/breathing_led_pwm_controller.sv =====
// ----------------------------------------------------------------------------
// breathing_led_pwm_controller
// Triangle-wave duty generator for LED breathing, with ADC-driven step size
// and a button that toggles the output on and off.
// ----------------------------------------------------------------------------
// An accepted item's result is registered and appears on m_tdata in the next cycle.
// Throughput: one item per cycle while no result waits or m_tready is high; the whole
// update (add, compare, duty-by-top and ADC-by-gain multiplies) sits between the state
// registers and the result register; a waiting result stalls the input while m_tready is low.
// Reset (aresetn low, synchronous): registers to defaults, duty at half,
// rising, enabled, no result pending.
module breathing_led_pwm_controller #(
    parameter int DUTY_BITS = 16,
    parameter int ADC_BITS  = 10
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [blpc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [blpc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    // input items
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // tdata: adc_value [ADC_BITS-1:0], button_low [ADC_BITS], zero pad
    input  logic [((ADC_BITS + 8) / 8) * 8 - 1:0]  s_tdata,
    // tuser: op [1:0]
    input  logic [blpc_pkg::OP_W-1:0]              s_tuser,
    // result items
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // tdata: compare_value [7:0], pwm_enabled [8], zero pad
    output logic [blpc_pkg::OUT_DATA_W-1:0]        m_tdata
);
    import blpc_pkg::*;

    localparam int SW   = (DUTY_BITS > STEP_CFG_W) ? DUTY_BITS : STEP_CFG_W;
    localparam int SUMW = SW + 1;
    localparam int PW   = DUTY_BITS + CMP_W;
    localparam int AW   = ADC_BITS + STEP_CFG_W;

    localparam logic [SUMW-1:0] DUTY_FULL = {{(SUMW-1){1'b0}}, 1'b1} << DUTY_BITS;
    localparam logic [SUMW-1:0] DUTY_MAX  = DUTY_FULL - {{(SUMW-1){1'b0}}, 1'b1};
    localparam logic [DUTY_BITS-1:0] DUTY_RST = DUTY_BITS'(RST_DUTY);

    // configuration registers
    logic [CMP_W-1:0]      top_count_reg;
    logic [STEP_CFG_W-1:0] min_step_reg;
    logic [STEP_CFG_W-1:0] step_gain_reg;

    // block state
    logic [DUTY_BITS-1:0]  duty_reg,    duty_next;
    logic [SW-1:0]         step_reg,    step_next;
    logic                  rising_reg,  rising_next;
    logic                  held_reg,    held_next;
    logic                  enabled_reg, enabled_next;
    logic [CMP_W-1:0]      cmp_reg,     cmp_next;

    // result register
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // unpacked input item
    op_t                   op;
    logic [ADC_BITS-1:0]   adc_value;
    logic                  button_low;
    logic                  accept;

    // tick datapath
    logic [SUMW-1:0]       duty_ext, step_ext, duty_sum, duty_diff;
    logic                  rise_t;
    logic [DUTY_BITS-1:0]  duty_t;
    logic [PW-1:0]         cmp_prod;
    logic [CMP_W-1:0]      cmp_t;

    // step datapath
    logic [AW-1:0]         adc_prod;
    logic [SUMW-1:0]       step_sum;

    assign op         = op_t'(s_tuser);
    assign adc_value  = s_tdata[ADC_BITS-1:0];
    assign button_low = s_tdata[ADC_BITS];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // next duty on a tick: turn at the ends, bottom test wins
    always_comb begin
        duty_ext  = SUMW'(duty_reg);
        step_ext  = SUMW'(step_reg);
        duty_sum  = duty_ext + step_ext;
        duty_diff = duty_ext - step_ext;
        if (duty_ext < step_ext) begin
            rise_t = 1'b1;
        end else if (duty_sum > DUTY_FULL) begin
            rise_t = 1'b0;
        end else begin
            rise_t = rising_reg;
        end
        if (rise_t) begin
            duty_t = (duty_sum > DUTY_MAX) ? DUTY_MAX[DUTY_BITS-1:0]
                                           : duty_sum[DUTY_BITS-1:0];
        end else begin
            duty_t = (duty_ext >= step_ext) ? duty_diff[DUTY_BITS-1:0]
                                            : '0;
        end
        cmp_prod = PW'(duty_t) * PW'(top_count_reg);
        cmp_t    = cmp_prod[PW-1:DUTY_BITS];
        if (cmp_t > top_count_reg) begin
            cmp_t = top_count_reg;
        end
    end

    // step from a potentiometer sample, saturated at full scale
    always_comb begin
        adc_prod = AW'(adc_value) * AW'(step_gain_reg);
        step_sum = SUMW'(min_step_reg) + SUMW'(adc_prod[AW-1:ADC_BITS]);
        if (step_sum > DUTY_MAX) begin
            step_sum = DUTY_MAX;
        end
    end

    // event decode
    always_comb begin
        duty_next    = duty_reg;
        step_next    = step_reg;
        rising_next  = rising_reg;
        held_next    = held_reg;
        enabled_next = enabled_reg;
        cmp_next     = cmp_reg;
        unique case (op)
            OP_TICK: begin
                if (enabled_reg) begin
                    duty_next   = duty_t;
                    rising_next = rise_t;
                    cmp_next    = cmp_t;
                end
            end
            OP_ADC: begin
                step_next = step_sum[SW-1:0];
            end
            OP_BUTTON: begin
                if (button_low) begin
                    if (!held_reg) begin
                        held_next    = 1'b1;
                        enabled_next = !enabled_reg;
                    end
                end else begin
                    held_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_count_reg <= RST_TOP_COUNT;
            min_step_reg  <= RST_MIN_STEP;
            step_gain_reg <= RST_STEP_GAIN;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_TOP_COUNT: top_count_reg <= cfg_wdata[CMP_W-1:0];
                CFG_MIN_STEP:  min_step_reg  <= cfg_wdata;
                CFG_STEP_GAIN: step_gain_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg     <= DUTY_RST;
            step_reg     <= SW'(RST_STEP);
            rising_reg   <= 1'b1;
            held_reg     <= 1'b0;
            enabled_reg  <= 1'b1;
            cmp_reg      <= RST_COMPARE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                duty_reg     <= duty_next;
                step_reg     <= step_next;
                rising_reg   <= rising_next;
                held_reg     <= held_next;
                enabled_reg  <= enabled_next;
                cmp_reg      <= cmp_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {{(OUT_DATA_W - CMP_W - 1){1'b0}}, enabled_next, cmp_next};
        end
    end

endmodule

// ===== src/blpc_checker.sv =====
// ----------------------------------------------------------------------------
// blpc_checker
// Port-level assertions for the breathing LED PWM controller.
// ----------------------------------------------------------------------------
module blpc_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    // tuser: op
    input logic [blpc_pkg::OP_W-1:0]             s_tuser,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    // tdata: compare_value, pwm_enabled, zero pad
    input logic [blpc_pkg::OUT_DATA_W-1:0]       m_tdata
);
    import blpc_pkg::*;

    // every accepted item yields a result on the next cycle
    a_item_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item produced no result");

    // input is open whenever the result register is empty
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no result pending");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // an item that is not a button poll leaves the enable flag unchanged
    a_enable_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && s_tvalid && s_tready
        && (s_tuser != OP_BUTTON)
        |=> m_tdata[CMP_W] == $past(m_tdata[CMP_W]))
        else $error("enable changed without a button poll");

endmodule

bind breathing_led_pwm_controller blpc_checker u_blpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the breathing LED PWM controller. A short table of
// events (reset state, button press and release, idle ticks, unused op,
// largest and smallest step) runs first. Six register settings follow, the
// extremes among them, each with a few hundred random events. A behavioral
// copy of the duty wave, step size and button logic predicts every result.
// Both stream sides stall at random, except in the last two phases.
// ----------------------------------------------------------------------------
module testbench;
    import blpc_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 9;
    localparam int STALL_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 305;
    localparam int MAX_REPORTS     = 10;
    localparam int DIR_ROWS        = 22;
    localparam int unsigned DUTY_FULL = 65536;
    localparam int unsigned DUTY_MAX  = 65535;
    // op value with no meaning; the block just reports its state
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0] compare;
        logic       enabled;
    } led_result_t;

    typedef struct {
        logic [OP_W-1:0] op;
        logic [9:0]      adc;
        logic            btn;
        bit              known;
        logic [7:0]      compare;
        logic            enabled;
    } event_row_t;

    // DUT signals, all inputs known from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int send_idle = 13;
    int recv_idle = 85;
    int fail_count = 0;

    led_result_t awaited[$];

    // Behavioral state of the controller
    int unsigned duty_lvl, step_lvl;
    int unsigned top_cfg, min_step_cfg, gain_cfg;
    bit          going_up, btn_held, running;
    logic [7:0]  cmp_now;

    event_row_t event_rows[DIR_ROWS];

    always #HALF_PERIOD aclk = ~aclk;

    breathing_led_pwm_controller uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    function automatic void breath_reset();
        top_cfg      = 32'(RST_TOP_COUNT);
        min_step_cfg = 32'(RST_MIN_STEP);
        gain_cfg     = 32'(RST_STEP_GAIN);
        duty_lvl     = 32768;
        step_lvl     = 32'(RST_STEP);
        going_up     = 1'b1;
        btn_held     = 1'b0;
        running      = 1'b1;
        cmp_now      = RST_COMPARE;
    endfunction

    function automatic void breath_write(cfg_idx_t idx, logic [15:0] val);
        case (idx)
            CFG_TOP_COUNT: top_cfg      = 32'(val[7:0]);
            CFG_MIN_STEP:  min_step_cfg = 32'(val);
            CFG_STEP_GAIN: gain_cfg     = 32'(val);
            default: ;
        endcase
    endfunction

    // One event through the controller; returns the reported compare/enable
    function automatic led_result_t breath_event(logic [OP_W-1:0] op, logic [9:0] adc,
                                                 logic btn);
        int unsigned level;
        led_result_t r;
        case (op)
            OP_TICK: begin
                if (running) begin
                    // bottom test after top test, so the bottom wins
                    if (duty_lvl + step_lvl > DUTY_FULL) going_up = 1'b0;
                    if (duty_lvl < step_lvl) going_up = 1'b1;
                    if (going_up) begin
                        duty_lvl = duty_lvl + step_lvl;
                        if (duty_lvl > DUTY_MAX) duty_lvl = DUTY_MAX;
                    end else begin
                        duty_lvl = duty_lvl - step_lvl;
                    end
                    level = (duty_lvl * top_cfg) >> 16;
                    if (level > top_cfg) level = top_cfg;
                    cmp_now = level[7:0];
                end
            end
            OP_ADC: begin
                level = min_step_cfg + ((adc * gain_cfg) >> 10);
                step_lvl = (level > DUTY_MAX) ? DUTY_MAX : level;
            end
            OP_BUTTON: begin
                if (btn) begin
                    if (!btn_held) begin
                        btn_held = 1'b1;
                        running  = !running;
                    end
                end else begin
                    btn_held = 1'b0;
                end
            end
            default: ;
        endcase
        r.compare = cmp_now;
        r.enabled = running;
        return r;
    endfunction

    // Present one item, wait for acceptance, queue what it should produce
    task automatic send_item(input logic [OP_W-1:0] op, input logic [9:0] adc,
                             input logic btn, input bit known, input led_result_t typed);
        led_result_t pred;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, btn, adc};
        do @(posedge aclk); while (!s_tready);
        pred = breath_event(op, adc, btn);
        awaited.push_back(known ? typed : pred);
    endtask

    // Mostly ticks so the wave travels; some step changes, button polls and spare ops
    task automatic send_random();
        int pick;
        logic [OP_W-1:0] op;
        logic [9:0] adc;
        pick = $urandom_range(99);
        if (pick < 68)      op = OP_TICK;
        else if (pick < 80) op = OP_ADC;
        else if (pick < 95) op = OP_BUTTON;
        else                op = OP_SPARE;
        if ($urandom_range(1) == 1) adc = 10'($urandom_range(1023));
        else                        adc = 10'($urandom_range(127));
        send_item(op, adc, 1'($urandom_range(1)), 1'b0, '0);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        breath_write(idx, val);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (awaited.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Receiver stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Result checker
    always @(posedge aclk) begin
        led_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result item: compare %0d enabled %0d",
                             m_tdata[7:0], m_tdata[8]);
            end else begin
                want = awaited.pop_front();
                if (m_tdata[7:0] !== want.compare || m_tdata[8] !== want.enabled) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch: compare exp %0d got %0d, enabled exp %0d got %0d",
                                 want.compare, m_tdata[7:0], want.enabled, m_tdata[8]);
                end
            end
        end
    end

    // Watchdog: cycles with no item moving on either side
    initial begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall = 0;
            else stall++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        logic [15:0] top_v, min_v, gain_v;
        led_result_t typed;
        event_rows = '{
            '{OP_SPARE,  10'd0,    1'b0, 1'b1, 8'd83, 1'b1},  // reset state
            '{OP_BUTTON, 10'd1023, 1'b1, 1'b1, 8'd83, 1'b0},  // press stops
            '{OP_TICK,   10'd0,    1'b0, 1'b1, 8'd83, 1'b0},  // tick while stopped
            '{OP_BUTTON, 10'd0,    1'b1, 1'b1, 8'd83, 1'b0},  // still held
            '{OP_SPARE,  10'd1023, 1'b1, 1'b1, 8'd83, 1'b0},
            '{OP_BUTTON, 10'd0,    1'b0, 1'b1, 8'd83, 1'b0},  // release
            '{OP_BUTTON, 10'd0,    1'b1, 1'b1, 8'd83, 1'b1},  // new press restarts
            '{OP_BUTTON, 10'd1023, 1'b0, 1'b1, 8'd83, 1'b1},
            '{OP_ADC,    10'd1023, 1'b0, 1'b1, 8'd83, 1'b1},  // largest step
            '{OP_TICK,   10'd0,    1'b0, 1'b0, 8'd0,  1'b0},
            '{OP_TICK,   10'd1023, 1'b1, 1'b0, 8'd0,  1'b0},  // turns at top
            '{OP_TICK,   10'd0,    1'b0, 1'b0, 8'd0,  1'b0},
            '{OP_TICK,   10'd0,    1'b0, 1'b0, 8'd0,  1'b0},  // turns at bottom
            '{OP_TICK,   10'd0,    1'b0, 1'b0, 8'd0,  1'b0},
            '{OP_ADC,    10'd0,    1'b1, 1'b0, 8'd0,  1'b0},  // back to min step
            '{OP_TICK,   10'd0,    1'b0, 1'b0, 8'd0,  1'b0},
            '{OP_TICK,   10'd0,    1'b0, 1'b0, 8'd0,  1'b0},
            '{OP_ADC,    10'd512,  1'b0, 1'b0, 8'd0,  1'b0},
            '{OP_TICK,   10'd0,    1'b0, 1'b0, 8'd0,  1'b0},
            '{OP_TICK,   10'd0,    1'b0, 1'b0, 8'd0,  1'b0},
            '{OP_ADC,    10'd1,    1'b0, 1'b0, 8'd0,  1'b0},
            '{OP_TICK,   10'd0,    1'b0, 1'b0, 8'd0,  1'b0}
        };
        breath_reset();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed events under reset register values
        foreach (event_rows[i]) begin
            typed.compare = event_rows[i].compare;
            typed.enabled = event_rows[i].enabled;
            send_item(event_rows[i].op, event_rows[i].adc, event_rows[i].btn,
                      event_rows[i].known, typed);
        end
        wait_drained();

        // Random events under several register settings
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin top_v = 16'd167; min_v = 16'd393; gain_v = 16'd21627; end
                1: begin top_v = 16'd1;   min_v = 16'd0;   gain_v = 16'd0;     end
                2: begin top_v = 16'd255; min_v = 16'hFFFF; gain_v = 16'hFFFF; end
                3: begin
                    top_v  = 16'($urandom_range(255, 1));
                    min_v  = 16'($urandom_range(2047));
                    gain_v = 16'($urandom_range(65535));
                end
                4: begin top_v = 16'd255; min_v = 16'd0; gain_v = 16'hFFFF; end
                default: begin
                    top_v  = 16'($urandom_range(255, 1));
                    min_v  = 16'($urandom_range(65535));
                    gain_v = 16'($urandom_range(65535));
                end
            endcase
            if (phase < 2) begin
                send_idle = 13;
                recv_idle = 85;
            end else if (phase < 4) begin
                send_idle = 85;
                recv_idle = 13;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_reg(CFG_TOP_COUNT, top_v);
            write_reg(CFG_MIN_STEP, min_v);
            write_reg(CFG_STEP_GAIN, gain_v);
            cfg_we <= 1'b0;
            repeat (ITEMS_PER_PHASE) send_random();
            wait_drained();
        end

        if (fail_count == 0 && awaited.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== breathing_led_pwm_controller.f =====
src/blpc_pkg.sv
src/breathing_led_pwm_controller.sv
src/blpc_checker.sv
tb/sv/testbench.sv
